@@ rtl/ttw_pkg.sv @@
`timescale 1ns / 1ps

package ttw_pkg;

    localparam int MAX_COLS     = 80;
    localparam int MAX_ROWS     = 25;
    localparam int STORE_DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int COL_W        = 7;
    localparam int ROW_W        = 5;
    localparam int CHAR_W       = 8;
    localparam int ATTR_W       = 8;
    localparam int CELL_W       = CHAR_W + ATTR_W;
    localparam int POS_W        = 11;
    localparam int CURSOR_PITCH = 80;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    localparam logic [COL_W-1:0]  WIDTH_RESET  = 7'd80;
    localparam logic [ROW_W-1:0]  HEIGHT_RESET = 5'd25;
    localparam logic [ATTR_W-1:0] COLOR_RESET  = 8'd7;
    localparam logic [COL_W-1:0]  WIDTH_MIN    = 7'd2;
    localparam logic [ROW_W-1:0]  HEIGHT_MIN   = 5'd1;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_COLOR  = 2'd2;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_BLANK,
        ST_CLEAR,
        ST_RESP
    } state_t;

    // effective (saturated) configuration
    typedef struct packed {
        logic [COL_W-1:0]  width;
        logic [ROW_W-1:0]  height;
        logic [ATTR_W-1:0] color;
    } cfg_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    // first member lands in the high bits: cursor_row is bit 0 up
    typedef struct packed {
        logic [CELL_W-1:0] read_cell;
        logic [POS_W-1:0]  cursor_position;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
    } res_t;

endpackage

@@ rtl/ttw_screen_ram.sv @@
`timescale 1ns / 1ps

module ttw_screen_ram #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = 16
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/ttw_ctrl.sv @@
`timescale 1ns / 1ps

module ttw_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ttw_pkg::cfg_t                   cfg,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_op,
    input  logic [ttw_pkg::CHAR_W-1:0]      s_ch,
    input  logic [ttw_pkg::ADDR_W-1:0]      s_idx,
    output logic                            m_valid,
    input  logic                            m_ready,
    output ttw_pkg::res_t                   m_res,
    output ttw_pkg::ram_req_t               ram_req,
    input  logic [ttw_pkg::CELL_W-1:0]      ram_rdata
);

    localparam int AW = ttw_pkg::ADDR_W;
    localparam int CW = ttw_pkg::COL_W;
    localparam int RW = ttw_pkg::ROW_W;

    ttw_pkg::state_t state_reg, state_next;

    ttw_pkg::op_t            op_reg;
    logic [ttw_pkg::CHAR_W-1:0] ch_reg;
    logic                    addr_ok_reg;
    logic [CW-1:0]           cur_x_reg;
    logic [RW-1:0]           cur_y_reg;
    logic [CW-1:0]           wr_x_reg;
    logic [RW-1:0]           wr_y_reg;
    logic [ttw_pkg::CHAR_W-1:0] wr_ch_reg;
    logic                    do_write_reg;
    logic                    do_scroll_reg;
    logic [AW-1:0]           area_reg;
    logic [AW-1:0]           ptr_reg;
    logic                    pend_reg;
    logic [AW-1:0]           pend_addr_reg;
    logic                    m_valid_reg;
    ttw_pkg::res_t           m_res_reg;

    logic accept;
    logic out_free;
    logic load_res;
    logic scroll_rd;
    logic [AW-1:0] moved;
    logic [AW-1:0] wr_addr;
    ttw_pkg::res_t res_now;

    // put-character decode on the incoming item
    logic          nl, bs, plain, wrap, scroll;
    logic [CW-1:0] cx, x1, x2, put_x, put_wx;
    logic [RW-1:0] cy, y1, y2, y3;
    logic          put_write;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign moved    = area_reg - AW'(cfg.width);
    assign wr_addr  = AW'(wr_y_reg) * AW'(cfg.width) + AW'(wr_x_reg);
    assign scroll_rd = (ptr_reg < area_reg);

    always_comb begin
        nl    = (s_ch == ttw_pkg::CH_NEWLINE);
        bs    = (s_ch == ttw_pkg::CH_BACKSPACE);
        plain = !nl && !bs;
        cy = (cur_y_reg >= cfg.height) ? cfg.height - RW'(1) : cur_y_reg;
        cx = (cur_x_reg >= cfg.width)  ? cfg.width - CW'(1)  : cur_x_reg;
        if (nl) begin
            x1 = '0;
            y1 = cy + RW'(1);
        end else if (bs && cx != '0) begin
            x1 = cx - CW'(1);
            y1 = cy;
        end else begin
            x1 = cx;
            y1 = cy;
        end
        wrap   = ({1'b0, x1} + (CW+1)'(1)) >= {1'b0, cfg.width};
        x2     = wrap ? '0 : x1;
        y2     = wrap ? y1 + RW'(1) : y1;
        scroll = (y2 >= cfg.height);
        y3     = scroll ? y2 - RW'(1) : y2;
        put_x  = plain ? x2 + CW'(1) : x2;
        put_wx = plain ? x2 : x1;
        put_write = plain || (bs && cx != '0);
    end

    always_comb begin
        res_now.cursor_row      = cur_y_reg;
        res_now.cursor_col      = cur_x_reg;
        res_now.cursor_position = ttw_pkg::POS_W'(cur_y_reg) *
                                  ttw_pkg::POS_W'(ttw_pkg::CURSOR_PITCH) +
                                  ttw_pkg::POS_W'(cur_x_reg);
        res_now.read_cell = (op_reg == ttw_pkg::OP_READ && addr_ok_reg) ? ram_rdata : '0;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ttw_pkg::ST_IDLE: begin
                if (accept) state_next = ttw_pkg::ST_EXEC;
            end
            ttw_pkg::ST_EXEC: begin
                if (op_reg == ttw_pkg::OP_PUT && do_scroll_reg) begin
                    state_next = ttw_pkg::ST_SCROLL;
                end else if (op_reg == ttw_pkg::OP_CLEAR) begin
                    state_next = ttw_pkg::ST_CLEAR;
                end else if (out_free) begin
                    state_next = ttw_pkg::ST_IDLE;
                end else begin
                    state_next = ttw_pkg::ST_RESP;
                end
            end
            ttw_pkg::ST_SCROLL: begin
                if (!scroll_rd && !pend_reg) state_next = ttw_pkg::ST_BLANK;
            end
            ttw_pkg::ST_BLANK: begin
                if (ptr_reg == area_reg - AW'(1)) state_next = ttw_pkg::ST_EXEC;
            end
            ttw_pkg::ST_CLEAR: begin
                if (ptr_reg == area_reg - AW'(1)) state_next = ttw_pkg::ST_RESP;
            end
            ttw_pkg::ST_RESP: begin
                if (out_free) state_next = ttw_pkg::ST_IDLE;
            end
            default: state_next = ttw_pkg::ST_IDLE;
        endcase
    end

    // outputs: handshake, memory port, result load
    always_comb begin
        s_ready  = 1'b0;
        load_res = 1'b0;
        ram_req  = '0;
        case (state_reg)
            ttw_pkg::ST_IDLE: begin
                s_ready       = 1'b1;
                ram_req.re    = accept && (s_op == ttw_pkg::OP_READ) &&
                                (s_idx < AW'(ttw_pkg::STORE_DEPTH));
                ram_req.raddr = s_idx;
            end
            ttw_pkg::ST_EXEC: begin
                if (!(op_reg == ttw_pkg::OP_PUT && do_scroll_reg) &&
                    op_reg != ttw_pkg::OP_CLEAR) begin
                    ram_req.we    = (op_reg == ttw_pkg::OP_PUT) && do_write_reg;
                    ram_req.waddr = wr_addr;
                    ram_req.wdata = {cfg.color, wr_ch_reg};
                    load_res      = out_free;
                end
            end
            ttw_pkg::ST_SCROLL: begin
                // read runs one row ahead of the write, so no entry is read after it moves
                ram_req.re    = scroll_rd;
                ram_req.raddr = ptr_reg;
                ram_req.we    = pend_reg;
                ram_req.waddr = pend_addr_reg;
                ram_req.wdata = ram_rdata;
            end
            ttw_pkg::ST_BLANK: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = ptr_reg;
                ram_req.wdata = {cfg.color, ttw_pkg::CH_SPACE};
            end
            ttw_pkg::ST_CLEAR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = ptr_reg;
                ram_req.wdata = {cfg.color, ch_reg};
            end
            ttw_pkg::ST_RESP: begin
                load_res = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ttw_pkg::ST_IDLE;
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept && s_op == ttw_pkg::OP_PUT) begin
                cur_x_reg <= put_x;
                cur_y_reg <= y3;
            end
            if (load_res) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            pend_reg <= (state_reg == ttw_pkg::ST_SCROLL) && scroll_rd;
        end
    end

    // item payload and sweep pointers
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg      <= ttw_pkg::op_t'(s_op);
            ch_reg      <= s_ch;
            addr_ok_reg <= (s_idx < AW'(ttw_pkg::STORE_DEPTH));
            area_reg    <= AW'(AW'(cfg.width) * AW'(cfg.height));
            wr_x_reg    <= put_wx;
            wr_y_reg    <= y3;
            wr_ch_reg   <= plain ? s_ch : ttw_pkg::CH_SPACE;
            do_write_reg  <= (s_op == ttw_pkg::OP_PUT) && put_write;
            do_scroll_reg <= (s_op == ttw_pkg::OP_PUT) && scroll;
        end
        case (state_reg)
            ttw_pkg::ST_EXEC: begin
                if (op_reg == ttw_pkg::OP_PUT && do_scroll_reg) begin
                    ptr_reg <= AW'(cfg.width);
                end else begin
                    ptr_reg <= '0;
                end
            end
            ttw_pkg::ST_SCROLL: begin
                if (scroll_rd) begin
                    ptr_reg       <= ptr_reg + AW'(1);
                    pend_addr_reg <= ptr_reg - AW'(cfg.width);
                end else if (!pend_reg) begin
                    ptr_reg <= moved;
                end
            end
            ttw_pkg::ST_BLANK: begin
                ptr_reg <= ptr_reg + AW'(1);
                if (ptr_reg == area_reg - AW'(1)) do_scroll_reg <= 1'b0;
            end
            ttw_pkg::ST_CLEAR: begin
                ptr_reg <= ptr_reg + AW'(1);
            end
            default: begin
                ptr_reg <= ptr_reg;
            end
        endcase
        if (load_res) m_res_reg <= res_now;
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

endmodule

@@ rtl/text_terminal_writer_core.sv @@
`timescale 1ns / 1ps
// Channel  | Direction | Handshake            | Payload
// s_       | in        | s_tvalid / s_tready  | s_tuser opcode, s_tdata char_code, cell_index
// m_       | out       | m_tvalid / m_tready  | m_tdata row, col, position, read_cell
// cfg_     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item at a time. Put character (no scroll), read and no-op: the result is loaded
// in the execute state, or in the response state while the output is stalled.
// Clear: one cell write per cycle on the memory port over the width*height area.
// Put that scrolls: rows move up, last row blanked, then the character is written.
// Reset sets the cursor to the top left and the registers to 80x25, attribute 7;
// the screen memory is not cleared. A stalled result is held in the output register
// while the next item is taken; that item waits for the register before finishing.

module text_terminal_writer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] char_code, [18:8] cell_index, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [4:0] cursor_row, [11:5] cursor_col,
                                   // [22:12] cursor_position, [38:23] read_cell, rest zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [ttw_pkg::COL_W-1:0]  width_reg;
    logic [ttw_pkg::ROW_W-1:0]  height_reg;
    logic [ttw_pkg::ATTR_W-1:0] color_reg;

    ttw_pkg::cfg_t     cfg;
    ttw_pkg::ram_req_t ram_req;
    ttw_pkg::res_t     m_res;
    logic [ttw_pkg::CELL_W-1:0] ram_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= ttw_pkg::WIDTH_RESET;
            height_reg <= ttw_pkg::HEIGHT_RESET;
            color_reg  <= ttw_pkg::COLOR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                ttw_pkg::REG_WIDTH:  width_reg  <= cfg_data[ttw_pkg::COL_W-1:0];
                ttw_pkg::REG_HEIGHT: height_reg <= cfg_data[ttw_pkg::ROW_W-1:0];
                ttw_pkg::REG_COLOR:  color_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // saturate to the area the store can hold
    always_comb begin
        if (width_reg < ttw_pkg::WIDTH_MIN) begin
            cfg.width = ttw_pkg::WIDTH_MIN;
        end else if (width_reg > ttw_pkg::COL_W'(ttw_pkg::MAX_COLS)) begin
            cfg.width = ttw_pkg::COL_W'(ttw_pkg::MAX_COLS);
        end else begin
            cfg.width = width_reg;
        end
        if (height_reg < ttw_pkg::HEIGHT_MIN) begin
            cfg.height = ttw_pkg::HEIGHT_MIN;
        end else if (height_reg > ttw_pkg::ROW_W'(ttw_pkg::MAX_ROWS)) begin
            cfg.height = ttw_pkg::ROW_W'(ttw_pkg::MAX_ROWS);
        end else begin
            cfg.height = height_reg;
        end
        cfg.color = color_reg;
    end

    ttw_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_op      (s_tuser),
        .s_ch      (s_tdata[7:0]),
        .s_idx     (s_tdata[18:8]),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_res     (m_res),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    ttw_screen_ram #(
        .DEPTH  (ttw_pkg::STORE_DEPTH),
        .ADDR_W (ttw_pkg::ADDR_W),
        .DATA_W (ttw_pkg::CELL_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    assign m_tdata = {1'b0, m_res};

endmodule

@@ rtl/ttw_checker.sv @@
`timescale 1ns / 1ps

module ttw_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    logic [10:0] pos_expect;

    assign pos_expect = 11'(m_tdata[4:0]) * 11'(ttw_pkg::CURSOR_PITCH) + 11'(m_tdata[11:5]);

    // a held result keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item in flight: no accept right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while previous one busy");

    a_position: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[22:12] == pos_expect) &&
                     (m_tdata[4:0] < 5'(ttw_pkg::MAX_ROWS)))
        else $error("cursor position inconsistent with row and column");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind text_terminal_writer_core ttw_checker u_ttw_checker (.*);
